// ===== design/cosine_lr_with_warmup_top_assert.svh =====
// assertion macros for the learning-rate schedule top level
// needs i_clk and i_rst_n in the scope of each use
`ifndef COSINE_LR_WITH_WARMUP_TOP_ASSERT_SVH
`define COSINE_LR_WITH_WARMUP_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AST_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("schedule assertion failed");

// next-cycle implication, checked outside reset
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("schedule assertion failed");

`endif

// ===== design/cosw_pkg.sv =====
// shared types and constants for the schedule pipeline
// no dependencies
package cosw_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int COS_DEPTH  = 256;
    localparam int IDX_W      = $clog2(COS_DEPTH) + 1;
    localparam int P_SHIFT    = $clog2(2 * COS_DEPTH);
    localparam int DIV_STAGES = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [31:0] Q30_ONE     = 32'd1073741824;
    localparam longint unsigned HALF_PI = 64'd1686629713;

    typedef enum logic [1:0] {
        PH_WARM  = 2'd0,
        PH_DECAY = 2'd1,
        PH_FLOOR = 2'd2
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PEAK   = 3'd0,
        REG_FLOOR  = 3'd1,
        REG_START  = 3'd2,
        REG_WARMUP = 3'd3,
        REG_DECAY  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] peak;
        logic [31:0] floor_r;
        logic [31:0] start_r;
        logic [31:0] warmup;
        logic [31:0] decay;
    } t_cfg;

    // item traveling through the divider
    typedef struct packed {
        logic   vld;
        t_phase ph;
    } t_tag;

endpackage

// ===== design/cosine_lr_with_warmup_top.sv =====
// the result strobe rises once its start transfer has passed the front, divider and back stages
// throughput: one step index per cycle; every stage, the 32 divider stages too, is pipelined
// busy stays low; the receiver cannot stall and needs no backpressure
// synchronous active-low reset clears all valid bits and loads register defaults
// depends on cosw_pkg, cosw_front, cosw_div, cosw_back and the assertion header
`include "cosine_lr_with_warmup_top_assert.svh"
module cosine_lr_with_warmup_top import cosw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [31:0]          i_step_index,
    output logic                 o_valid,
    output logic [31:0]          o_rate_out,
    output logic [1:0]           o_phase,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cfg        r_cfg;
    t_tag        w_front_tag;
    logic [63:0] w_num;
    logic [31:0] w_den;
    t_tag        w_div_tag;
    logic [31:0] w_quo;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peak    <= 32'(1) << FRAC_BITS;
            r_cfg.floor_r <= '0;
            r_cfg.start_r <= '0;
            r_cfg.warmup  <= '0;
            r_cfg.decay   <= 32'd1000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PEAK:   r_cfg.peak    <= i_cfg_data;
                REG_FLOOR:  r_cfg.floor_r <= i_cfg_data;
                REG_START:  r_cfg.start_r <= i_cfg_data;
                REG_WARMUP: r_cfg.warmup  <= i_cfg_data;
                REG_DECAY:  r_cfg.decay   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cosw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_step  (i_step_index),
        .i_cfg   (r_cfg),
        .o_tag   (w_front_tag),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    cosw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_front_tag),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_tag   (w_div_tag),
        .o_quo   (w_quo)
    );

    cosw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_div_tag),
        .i_quo   (w_quo),
        .i_cfg   (r_cfg),
        .o_valid (o_valid),
        .o_rate  (o_rate_out),
        .o_phase (o_phase)
    );

    `AST_IMPL(a_floor_hold, o_valid && (o_phase == PH_FLOOR), o_rate_out == r_cfg.floor_r)
    `AST_IMPL(a_ramp_bound, o_valid && (o_phase == PH_WARM),
        ((o_rate_out >= r_cfg.start_r) && (o_rate_out <= r_cfg.peak)) ||
        ((o_rate_out <= r_cfg.start_r) && (o_rate_out >= r_cfg.peak)))
    `AST_IMPL(a_decay_bound, o_valid && (o_phase == PH_DECAY),
        ((o_rate_out >= r_cfg.floor_r) && (o_rate_out <= r_cfg.peak)) ||
        ((o_rate_out <= r_cfg.floor_r) && (o_rate_out >= r_cfg.peak)))
    `AST_IMPL(a_phase_legal, o_valid, o_phase <= PH_FLOOR)

endmodule

// ===== design/cosw_front.sv =====
// front stages: phase decision, ramp product and dividend setup
// depends on cosw_pkg
module cosw_front import cosw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [31:0] i_step,
    input  t_cfg        i_cfg,
    output t_tag        o_tag,
    output logic [63:0] o_num,
    output logic [31:0] o_den
);

    logic        r_v0;
    logic [31:0] r_step0;

    logic        r_v1;
    t_phase      r_ph1;
    logic [31:0] r_step1;
    logic [31:0] r_d1;
    logic [31:0] r_diff1;

    logic        r_v2;
    t_phase      r_ph2;
    logic [63:0] r_num2;
    logic [31:0] r_den2;

    logic [32:0] w_total;
    t_phase      w_ph;

    assign w_total = {1'b0, i_cfg.warmup} + {1'b0, i_cfg.decay};

    always_comb begin
        priority if ({1'b0, r_step0} >= w_total) begin
            w_ph = PH_FLOOR;
        end else if (r_step0 >= i_cfg.warmup) begin
            w_ph = PH_DECAY;
        end else begin
            w_ph = PH_WARM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_vld;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step0 <= i_step;
        r_ph1   <= w_ph;
        r_step1 <= r_step0;
        r_d1    <= r_step0 - i_cfg.warmup;
        r_diff1 <= (i_cfg.peak >= i_cfg.start_r) ? (i_cfg.peak - i_cfg.start_r)
                                                  : (i_cfg.start_r - i_cfg.peak);
        r_ph2   <= r_ph1;
        if (r_ph1 == PH_WARM) begin
            r_num2 <= 64'(r_diff1) * 64'(r_step1);
            r_den2 <= i_cfg.warmup;
        end else begin
            r_num2 <= 64'(r_d1) << P_SHIFT;
            r_den2 <= i_cfg.decay;
        end
    end

    assign o_tag = '{vld: r_v2, ph: r_ph2};
    assign o_num = r_num2;
    assign o_den = r_den2;

endmodule

// ===== design/cosw_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on cosw_pkg; quotient must fit in 32 bits
module cosw_div import cosw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tag        i_tag,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output t_tag        o_tag,
    output logic [31:0] o_quo
);

    logic        r_vld [1:DIV_STAGES];
    t_phase      r_ph  [1:DIV_STAGES];
    logic [31:0] r_rem [1:DIV_STAGES];
    logic [31:0] r_lo  [1:DIV_STAGES];
    logic [31:0] r_quo [1:DIV_STAGES];
    logic [31:0] r_den [1:DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic        w_vld;
        t_phase      w_ph;
        logic [31:0] w_rem;
        logic [31:0] w_lo;
        logic [31:0] w_quo;
        logic [31:0] w_den;
        logic [32:0] w_trial;
        logic        w_ge;

        if (g == 0) begin : g_first
            assign w_vld = i_tag.vld;
            assign w_ph  = i_tag.ph;
            assign w_rem = i_num[63:32];
            assign w_lo  = i_num[31:0];
            assign w_quo = '0;
            assign w_den = i_den;
        end else begin : g_next
            assign w_vld = r_vld[g];
            assign w_ph  = r_ph[g];
            assign w_rem = r_rem[g];
            assign w_lo  = r_lo[g];
            assign w_quo = r_quo[g];
            assign w_den = r_den[g];
        end

        assign w_trial = {w_rem, w_lo[31]};
        assign w_ge    = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_ph[g+1]  <= w_ph;
            r_rem[g+1] <= w_ge ? 32'(w_trial - {1'b0, w_den}) : w_trial[31:0];
            r_lo[g+1]  <= {w_lo[30:0], 1'b0};
            r_quo[g+1] <= {w_quo[30:0], w_ge};
            r_den[g+1] <= w_den;
        end
    end

    assign o_tag = '{vld: r_vld[DIV_STAGES], ph: r_ph[DIV_STAGES]};
    assign o_quo = r_quo[DIV_STAGES];

endmodule

// ===== design/cosw_back.sv =====
// back stages: cosine lookup, weight multiply and final rate
// depends on cosw_pkg
module cosw_back import cosw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tag        i_tag,
    input  logic [31:0] i_quo,
    input  t_cfg        i_cfg,
    output logic        o_valid,
    output logic [31:0] o_rate,
    output logic [1:0]  o_phase
);

    logic [31:0]      w_cos_tab [0:COS_DEPTH];

    logic [IDX_W-1:0] w_p;
    logic [IDX_W-1:0] w_idx;
    logic [31:0]      w_cos;
    logic [31:0]      w_sum;

    logic        r_v1;
    t_phase      r_ph1;
    logic [31:0] r_quo1;
    logic [30:0] r_w1;
    logic [31:0] r_diff1;

    logic        r_v2;
    t_phase      r_ph2;
    logic [31:0] r_quo2;
    logic [61:0] r_prod2;

    logic        r_v3;
    t_phase      r_ph3;
    logic [31:0] r_rate3;

    logic [31:0] w_rate;

    // quarter-wave cosine in Q1.30 from ten Taylor terms, clamped to [0, 1]
    for (genvar k = 0; k <= COS_DEPTH; k++) begin : g_cos
        localparam longint unsigned X   = (HALF_PI * 64'(k)) / COS_DEPTH;
        localparam longint unsigned X2  = (X * X) >> 30;
        localparam longint unsigned T1  = ((64'(Q30_ONE) * X2) >> 30) / 2;
        localparam longint unsigned T2  = ((T1 * X2) >> 30) / 12;
        localparam longint unsigned T3  = ((T2 * X2) >> 30) / 30;
        localparam longint unsigned T4  = ((T3 * X2) >> 30) / 56;
        localparam longint unsigned T5  = ((T4 * X2) >> 30) / 90;
        localparam longint unsigned T6  = ((T5 * X2) >> 30) / 132;
        localparam longint unsigned T7  = ((T6 * X2) >> 30) / 182;
        localparam longint unsigned T8  = ((T7 * X2) >> 30) / 240;
        localparam longint unsigned T9  = ((T8 * X2) >> 30) / 306;
        localparam longint unsigned T10 = ((T9 * X2) >> 30) / 380;
        localparam longint SUM = longint'(Q30_ONE)
                                 - longint'(T1) + longint'(T2) - longint'(T3)
                                 + longint'(T4) - longint'(T5) + longint'(T6)
                                 - longint'(T7) + longint'(T8) - longint'(T9)
                                 + longint'(T10);
        localparam longint CLAMPED = (SUM < 0) ? 0 :
                                     (SUM > longint'(Q30_ONE)) ? longint'(Q30_ONE) : SUM;
        assign w_cos_tab[k] = 32'(CLAMPED);
    end

    // second half of the wave mirrors the table and flips the sign
    assign w_p   = i_quo[IDX_W-1:0];
    assign w_idx = w_p[IDX_W-1] ? IDX_W'((IDX_W+1)'(2 * COS_DEPTH) - (IDX_W+1)'(w_p)) : w_p;
    assign w_cos = w_cos_tab[w_idx];
    assign w_sum = w_p[IDX_W-1] ? (Q30_ONE - w_cos) : (Q30_ONE + w_cos);

    always_comb begin
        unique case (r_ph2)
            PH_WARM: begin
                w_rate = (i_cfg.peak >= i_cfg.start_r) ? (i_cfg.start_r + r_quo2)
                                                        : (i_cfg.start_r - r_quo2);
            end
            PH_DECAY: begin
                w_rate = (i_cfg.peak >= i_cfg.floor_r) ? (i_cfg.floor_r + r_prod2[61:30])
                                                        : (i_cfg.floor_r - r_prod2[61:30]);
            end
            default: begin
                w_rate = i_cfg.floor_r;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_tag.vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph1   <= i_tag.ph;
        r_quo1  <= i_quo;
        r_w1    <= w_sum[31:1];
        r_diff1 <= (i_cfg.peak >= i_cfg.floor_r) ? (i_cfg.peak - i_cfg.floor_r)
                                                  : (i_cfg.floor_r - i_cfg.peak);
        r_ph2   <= r_ph1;
        r_quo2  <= r_quo1;
        r_prod2 <= 62'(r_diff1) * 62'(r_w1);
        r_ph3   <= r_ph2;
        r_rate3 <= w_rate;
    end

    // r_ph2 selects the final adder; r_ph3 travels with the registered rate
    assign o_valid = r_v3;
    assign o_rate  = r_rate3;
    assign o_phase = r_ph3;

endmodule

// ===== tb/tb_cosine_lr_with_warmup_top.sv =====
// testbench for the cosine learning-rate schedule with linear warmup
// depends on cosw_pkg and cosine_lr_with_warmup_top; predicts each rate and phase locally
module tb_cosine_lr_with_warmup_top;
    import cosw_pkg::*;

    localparam int LATENCY   = 38;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 550;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [31:0]          i_step_index = '0;
    logic                 o_valid;
    logic [31:0]          o_rate_out;
    logic [1:0]           o_phase;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    typedef struct {
        logic [31:0] rate;
        t_phase      ph;
    } t_sched;

    typedef struct {
        logic [31:0] step;
        bit          known;
        t_sched      res;
    } t_row;

    cosine_lr_with_warmup_top DUT (.*);

    always #6 i_clk = ~i_clk;

    // local copy of the schedule registers
    logic [31:0] m_peak, m_floor, m_start, m_warm, m_decay;
    logic [31:0] cos_q30 [0:COS_DEPTH];
    t_sched      pending_rates [$];
    int          mismatches = 0;
    int          wdog = 0;
    int          quiet_run = 0;

    function automatic logic [31:0] lerp_rate(logic [31:0] from, logic [31:0] to,
                                              longint unsigned num, longint unsigned den);
        longint unsigned span;
        span = (to >= from) ? 64'(to - from) : 64'(from - to);
        if (to >= from) return from + 32'((span * num) / den);
        return from - 32'((span * num) / den);
    endfunction

    function automatic t_sched schedule_at(logic [31:0] step);
        t_sched          r;
        longint unsigned total, d, p, w;
        longint          c;
        total = 64'(m_warm) + 64'(m_decay);
        if (64'(step) >= total) begin
            r.rate = m_floor;
            r.ph   = PH_FLOOR;
        end else if (step >= m_warm) begin
            d = 64'(step - m_warm);
            p = (d * 2 * COS_DEPTH) / 64'(m_decay);
            if (p < COS_DEPTH) c = longint'(cos_q30[p]);
            else c = -longint'(cos_q30[2 * COS_DEPTH - p]);
            w = longint'(longint'(Q30_ONE) + c) >>> 1;
            r.rate = lerp_rate(m_floor, m_peak, w, 64'(Q30_ONE));
            r.ph   = PH_DECAY;
        end else begin
            r.rate = lerp_rate(m_start, m_peak, 64'(step), 64'(m_warm));
            r.ph   = PH_WARM;
        end
        return r;
    endfunction

    // independent build of the quarter-wave table
    initial begin
        longint unsigned x, x2, term;
        longint          acc;
        for (int k = 0; k <= COS_DEPTH; k++) begin
            x = (64'd1686629713 * k) / COS_DEPTH;
            x2 = (x * x) >> 30;
            term = 64'd1073741824;
            acc = 64'd1073741824;
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
                acc = (n % 2) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            if (acc > 64'd1073741824) acc = 64'd1073741824;
            cos_q30[k] = 32'(acc);
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_sched want;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) wdog <= 0;
            else wdog <= wdog + 1;
            if (o_valid) begin
                if (pending_rates.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result rate=%h", o_rate_out);
                end else begin
                    want = pending_rates.pop_front();
                    if (o_rate_out !== want.rate || o_phase !== want.ph) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch rate exp %h got %h phase exp %0d got %0d",
                                     want.rate, o_rate_out, want.ph, o_phase);
                    end
                end
            end
            if (wdog > WDOG_MAX) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_PEAK:   m_peak  = val;
            REG_FLOOR:  m_floor = val;
            REG_START:  m_start = val;
            REG_WARMUP: m_warm  = val;
            REG_DECAY:  m_decay = val;
            default: ;
        endcase
    endtask

    // unused index: transfer happens but nothing changes
    task automatic write_unused();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= IDX_UNUSED;
        i_cfg_data  <= $urandom;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_step(logic [31:0] step, bit known, t_sched res);
        t_sched pred;
        if (quiet_run > 0) quiet_run--;
        else while ($urandom_range(99) < 10) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_step_index <= step;
        pred = schedule_at(step);
        pending_rates = {pending_rates, (known ? res : pred)};
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_rates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_step(int sel);
        logic [31:0] top;
        top = m_warm + m_decay + 32'd20;
        case (sel)
            0: random_step = $urandom;
            1, 2: random_step = $urandom_range(m_warm + 3, (m_warm > 3) ? m_warm - 3 : 0);
            default: random_step = (top < m_warm) ? $urandom : $urandom_range(top, 0);
        endcase
    endfunction

    initial begin
        t_row tbl [$];
        t_sched z;
        m_peak = 32'h0100_0000; m_floor = 0; m_start = 0; m_warm = 0; m_decay = 32'd1000;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: no warmup, step 0 at peak, tail at floor
        tbl = {tbl, t_row'{32'd0, 1, '{32'h0100_0000, PH_DECAY}}};
        tbl = {tbl, t_row'{32'd999, 0, z}};
        tbl = {tbl, t_row'{32'd500, 0, z}};
        tbl = {tbl, t_row'{32'd1000, 1, '{32'd0, PH_FLOOR}}};
        tbl = {tbl, t_row'{32'hFFFF_FFFF, 1, '{32'd0, PH_FLOOR}}};
        foreach (tbl[i]) send_step(tbl[i].step, tbl[i].known, tbl[i].res);
        drain();

        // extremes: ramp downward, cosine upward, huge lengths
        write_unused();
        write_reg(REG_PEAK, 32'h0000_0000);
        write_reg(REG_START, 32'hFFFF_FFFF);
        write_reg(REG_FLOOR, 32'hFFFF_FFFF);
        write_reg(REG_WARMUP, 32'hFFFF_FFFF);
        write_reg(REG_DECAY, 32'hFFFF_FFFF);
        tbl.delete();
        tbl = {tbl, t_row'{32'd0, 1, '{32'hFFFF_FFFF, PH_WARM}}};
        tbl = {tbl, t_row'{32'hFFFF_FFFE, 0, z}};
        tbl = {tbl, t_row'{32'hFFFF_FFFF, 1, '{32'h0000_0000, PH_DECAY}}};
        tbl = {tbl, t_row'{32'h8000_0000, 0, z}};
        tbl = {tbl, t_row'{32'h5555_AAAA, 0, z}};
        foreach (tbl[i]) send_step(tbl[i].step, tbl[i].known, tbl[i].res);
        drain();

        // zero decay: floor right after warmup; then both zero
        write_reg(REG_DECAY, 32'd0);
        write_reg(REG_WARMUP, 32'd7);
        write_reg(REG_FLOOR, 32'h0123_4567);
        tbl.delete();
        tbl = {tbl, t_row'{32'd6, 0, z}};
        tbl = {tbl, t_row'{32'd7, 1, '{32'h0123_4567, PH_FLOOR}}};
        tbl = {tbl, t_row'{32'd3, 0, z}};
        foreach (tbl[i]) send_step(tbl[i].step, tbl[i].known, tbl[i].res);
        drain();
        write_reg(REG_WARMUP, 32'd0);
        send_step(32'd0, 1, '{32'h0123_4567, PH_FLOOR});
        send_step(32'hDEAD_BEEF, 1, '{32'h0123_4567, PH_FLOOR});
        drain();

        // random phases with random settings
        for (int ph = 0; ph < 11; ph++) begin
            write_reg(REG_PEAK, $urandom);
            write_reg(REG_FLOOR, (ph % 3 == 0) ? $urandom : $urandom_range(32'h0400_0000, 0));
            write_reg(REG_START, $urandom);
            write_reg(REG_WARMUP, (ph == 10) ? $urandom : $urandom_range(ph * 40, 0));
            write_reg(REG_DECAY, (ph == 9) ? $urandom : $urandom_range(1 + ph * 300, 1));
            if (ph == 4) quiet_run = 50;
            for (int n = 0; n < N_RANDOM / 11; n++) send_step(random_step($urandom_range(5)), 0, z);
            drain();
        end

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
